// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/ssc_pkg.sv -----
// Types, constants and helpers for the sorted score table.
package ssc_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int SCORE_W     = 32;
  localparam int RANK_W      = 6;

  typedef enum logic [1:0] {
    FUNC_UPDATE = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NOKEY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  // Broadcast to every cell at accept time.
  typedef struct packed {
    logic                      is_read;
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    logic [CNT_W-1:0]          rank;
    logic [CNT_W-1:0]          count;
  } cmp_t;

  // Broadcast to every cell in the commit cycle.
  typedef struct packed {
    logic             wr;
    logic             found;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] n_eff;
    entry_t           item;
  } ctx_t;

  // Passed from cell i to cell i+1.
  typedef struct packed {
    logic above;    // entry i of the list without the item lands above the item
    logic after;    // cell i sits at or past the old slot of the key
  } link_t;

  function automatic logic [IDX_W-1:0] onehot_enc(input logic [TABLE_DEPTH-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (v[i]) r = r | IDX_W'(i);
    end
    return r;
  endfunction

endpackage

// ----- rtl/ssc_cell.sv -----
// One table slot: holds an entry, compares it against the beat, shifts with its neighbors.
module ssc_cell import ssc_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  logic             cmp_en,
  input  cmp_t             cmp,
  input  ctx_t             ctx,
  input  entry_t           up_ent,
  input  logic             up_gt,
  input  entry_t           dn_ent,
  input  link_t            dn_link,
  output entry_t           ent,
  output logic             hit,
  output logic             gt,
  output link_t            link,
  output logic             slot
);

  entry_t ent_r, ent_nxt;
  logic   hit_r, hit_nxt;
  logic   ge_r, ge_nxt;
  logic   gt_r, gt_nxt;
  logic   valid;

  always_comb begin
    valid   = CNT_W'(idx) < cmp.count;
    hit_nxt = cmp.is_read ? (CNT_W'(idx) == cmp.rank) : (valid && ent_r.key == cmp.key);
    ge_nxt  = ent_r.score >= cmp.score;
    gt_nxt  = ent_r.score > cmp.score;
  end

  // above is a prefix of ones over the cells, so the first zero is the item's slot
  always_comb begin
    link.after = ctx.found && (idx >= ctx.pos);
    link.above = (CNT_W'(idx) < ctx.n_eff) && (link.after ? up_gt : ge_r);
    slot       = !link.above && dn_link.above;
    if (link.above) begin
      ent_nxt = link.after ? up_ent : ent_r;
    end else if (dn_link.above) begin
      ent_nxt = ctx.item;
    end else begin
      ent_nxt = dn_link.after ? ent_r : dn_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      hit_r <= hit_nxt;
      ge_r  <= ge_nxt;
      gt_r  <= gt_nxt;
    end
    if (ctx.wr) begin
      ent_r <= ent_nxt;
    end
  end

  assign ent = ent_r;
  assign hit = hit_r;
  assign gt  = gt_r;

endmodule

// ----- rtl/sorted_score_table.sv -----
// Sorted score table: up to TABLE_DEPTH (key, score) entries kept in descending
// score order in a row of cells, rank 0 best. Each item has an accept and a commit cycle: in the
// accept cycle every cell compares its key and score against the beat and latches
// the result; in the commit cycle every cell loads its new entry from itself, a
// neighbor or the item, and the result goes to the output register. A new item is
// taken the cycle after commit, never while the previous item is still in the block.
// Commit waits while the previous result is still held by out_stall. The entry
// storage needs no clearing after reset; only count, state and out_valid are reset.
module sorted_score_table import ssc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_func,
  input  logic [KEY_W-1:0]          in_player_key,
  input  logic signed [SCORE_W-1:0] in_new_score,
  input  logic [RANK_W-1:0]         in_rank_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_status,
  output logic [RANK_W-1:0]         out_rank_out,
  output logic [CNT_W-1:0]          out_entry_count,
  output logic [KEY_W-1:0]          out_entry_key,
  output logic signed [SCORE_W-1:0] out_entry_score
);

  state_t state_r, state_nxt;
  logic   [CNT_W-1:0] count_r, count_nxt;
  func_t  req_func_r;
  entry_t req_item_r;
  logic   [RANK_W-1:0] req_rank_r;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, res_status;
  logic [RANK_W-1:0]   out_rank_r, res_rank;
  logic [CNT_W-1:0]    out_count_r;
  entry_t              out_ent_r, res_ent;

  logic   accept, commit_go, found, is_full, do_write;
  logic   [IDX_W-1:0] key_pos, slot_pos;
  entry_t sel_ent;
  cmp_t   cmp;
  ctx_t   ctx;

  entry_t ent_v  [TABLE_DEPTH];
  link_t  link_v [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_v, gt_v, slot_v;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    cmp.is_read = (func_t'(in_func) == FUNC_READ);
    cmp.key     = in_player_key;
    cmp.score   = in_new_score;
    cmp.rank    = CNT_W'(in_rank_index);
    cmp.count   = count_r;
  end

  always_comb begin
    found    = |hit_v;
    key_pos  = onehot_enc(hit_v);
    slot_pos = onehot_enc(slot_v);
    is_full  = (req_func_r == FUNC_UPDATE) && !found && (count_r == CNT_W'(TABLE_DEPTH));
    do_write = commit_go && (req_func_r == FUNC_UPDATE) && !is_full;
    ctx.wr    = do_write;
    ctx.found = found;
    ctx.pos   = key_pos;
    ctx.n_eff = count_r - CNT_W'(found);
    ctx.item  = req_item_r;
    count_nxt = (do_write && !found) ? count_r + CNT_W'(1) : count_r;
  end

  // and-or readout of the selected cell
  always_comb begin
    sel_ent = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_v[i]) sel_ent = sel_ent | ent_v[i];
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t up_ent, dn_ent;
    logic   up_gt;
    link_t  dn_link;
    if (i == 0) begin : g_first
      assign dn_ent  = '0;
      assign dn_link = '{above: 1'b1, after: 1'b0};
    end else begin : g_mid_dn
      assign dn_ent  = ent_v[i-1];
      assign dn_link = link_v[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign up_ent = '0;
      assign up_gt  = 1'b0;
    end else begin : g_mid_up
      assign up_ent = ent_v[i+1];
      assign up_gt  = gt_v[i+1];
    end
    ssc_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(i)),
      .cmp_en  (accept),
      .cmp     (cmp),
      .ctx     (ctx),
      .up_ent  (up_ent),
      .up_gt   (up_gt),
      .dn_ent  (dn_ent),
      .dn_link (dn_link),
      .ent     (ent_v[i]),
      .hit     (hit_v[i]),
      .gt      (gt_v[i]),
      .link    (link_v[i]),
      .slot    (slot_v[i])
    );
  end

  always_comb begin
    res_status = ST_OK;
    res_rank   = '0;
    res_ent    = '0;
    unique case (req_func_r)
      FUNC_UPDATE: begin
        if (is_full) begin
          res_status = ST_FULL;
        end else begin
          res_rank = RANK_W'(slot_pos);
          res_ent  = req_item_r;
        end
      end
      FUNC_READ: begin
        res_rank = req_rank_r;
        if (CNT_W'(req_rank_r) < count_r) begin
          res_ent = sel_ent;
        end else begin
          res_status = ST_RANGE;
        end
      end
      FUNC_FIND: begin
        if (found) begin
          res_rank = RANK_W'(key_pos);
          res_ent  = sel_ent;
        end else begin
          res_status = ST_NOKEY;
        end
      end
      default: res_status = ST_RANGE;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = commit_go || (out_valid_r && out_stall);
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_COMMIT;
      S_COMMIT: if (commit_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func_r       <= func_t'(in_func);
      req_item_r.key   <= in_player_key;
      req_item_r.score <= in_new_score;
      req_rank_r       <= in_rank_index;
    end
    if (commit_go) begin
      out_status_r <= res_status;
      out_rank_r   <= res_rank;
      out_count_r  <= count_nxt;
      out_ent_r    <= res_ent;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_rank_out    = out_rank_r;
  assign out_entry_count = out_count_r;
  assign out_entry_key   = out_ent_r.key;
  assign out_entry_score = out_ent_r.score;

endmodule

// ----- rtl/ssc_checker.sv -----
// Port-level checks for the sorted score table, bound to the top level.
`include "assert_macros.svh"

module ssc_checker import ssc_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                out_status,
  input logic [RANK_W-1:0]         out_rank_out,
  input logic [CNT_W-1:0]          out_entry_count,
  input logic [KEY_W-1:0]          out_entry_key,
  input logic signed [SCORE_W-1:0] out_entry_score
);

  `SSC_ASSERT_NOW(a_full_count, out_valid && out_status == ST_FULL, out_entry_count == CNT_W'(TABLE_DEPTH))
  `SSC_ASSERT_NOW(a_ok_rank, out_valid && out_status == ST_OK, CNT_W'(out_rank_out) < out_entry_count)
  `SSC_ASSERT_NOW(a_miss_zero, out_valid && (out_status == ST_RANGE || out_status == ST_NOKEY), out_entry_key == '0 && out_entry_score == '0)
  `SSC_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)
  `SSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_entry_key) && $stable(out_rank_out))

endmodule

bind sorted_score_table ssc_checker u_ssc_checker (.*);

// ----- tb/sorted_score_table_tb.sv -----
// Self-checking testbench for sorted_score_table: mirrored ranking table, random beats, stalls.
module sorted_score_table_tb;
  import ssc_pkg::*;

  typedef struct {
    status_t                   status;
    logic [RANK_W-1:0]         rank;
    logic [CNT_W-1:0]          count;
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
  } score_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                in_func;
  logic [KEY_W-1:0]          in_player_key;
  logic signed [SCORE_W-1:0] in_new_score;
  logic [RANK_W-1:0]         in_rank_index;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                out_status;
  logic [RANK_W-1:0]         out_rank_out;
  logic [CNT_W-1:0]          out_entry_count;
  logic [KEY_W-1:0]          out_entry_key;
  logic signed [SCORE_W-1:0] out_entry_score;

  // mirror of the table contents
  logic [KEY_W-1:0]          mirror_key [TABLE_DEPTH];
  logic signed [SCORE_W-1:0] mirror_score [TABLE_DEPTH];
  int                        mirror_count = 0;

  score_result_t pending_results [$];
  int            err_cnt = 0;
  bit            calm = 1'b0;
  int            hold_seq = 0;
  int            hold_ack = 0;
  int            hold_left = 0;

  sorted_score_table dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_player_key   (in_player_key),
    .in_new_score    (in_new_score),
    .in_rank_index   (in_rank_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_rank_out    (out_rank_out),
    .out_entry_count (out_entry_count),
    .out_entry_key   (out_entry_key),
    .out_entry_score (out_entry_score)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int key_rank(input logic [KEY_W-1:0] k);
    for (int i = 0; i < mirror_count; i++) begin
      if (mirror_key[i] == k) return i;
    end
    return -1;
  endfunction

  // Applies one beat to the mirror and returns the result the block should give.
  function automatic score_result_t ranked_result(input func_t f,
                                                  input logic [KEY_W-1:0] k,
                                                  input logic signed [SCORE_W-1:0] s,
                                                  input logic [RANK_W-1:0] r);
    score_result_t res;
    int pos;
    res = '{ST_RANGE, '0, '0, '0, '0};
    case (f)
      FUNC_UPDATE: begin
        pos = key_rank(k);
        if (pos < 0 && mirror_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (pos < 0) begin
            pos = mirror_count;
            mirror_count++;
          end
          // bubble up past strictly lower, then down past strictly higher
          while (pos > 0 && s > mirror_score[pos-1]) begin
            mirror_key[pos]   = mirror_key[pos-1];
            mirror_score[pos] = mirror_score[pos-1];
            pos--;
          end
          while (pos + 1 < mirror_count && s < mirror_score[pos+1]) begin
            mirror_key[pos]   = mirror_key[pos+1];
            mirror_score[pos] = mirror_score[pos+1];
            pos++;
          end
          mirror_key[pos]   = k;
          mirror_score[pos] = s;
          res.status = ST_OK;
          res.rank   = RANK_W'(pos);
          res.key    = k;
          res.score  = s;
        end
      end
      FUNC_READ: begin
        res.rank = r;
        if (int'(r) < mirror_count) begin
          res.status = ST_OK;
          res.key    = mirror_key[r];
          res.score  = mirror_score[r];
        end
      end
      FUNC_FIND: begin
        pos = key_rank(k);
        if (pos < 0) begin
          res.status = ST_NOKEY;
        end else begin
          res.status = ST_OK;
          res.rank   = RANK_W'(pos);
          res.key    = mirror_key[pos];
          res.score  = mirror_score[pos];
        end
      end
      default: res.status = ST_RANGE;
    endcase
    res.count = CNT_W'(mirror_count);
    return res;
  endfunction

  task automatic send_beat(input func_t f, input logic [KEY_W-1:0] k,
                           input logic signed [SCORE_W-1:0] s, input logic [RANK_W-1:0] r);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 26) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_player_key <= k;
    in_new_score  <= s;
    in_rank_index <= r;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(ranked_result(f, k, s, r));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if (mirror_count > 0 && $urandom_range(0, 99) < 80)
      return mirror_key[$urandom_range(0, mirror_count - 1)];
    return $urandom;
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return SCORE_W'($signed($urandom_range(0, 4)) - 2) <<< 8;
    if (sel < 80) return $urandom;
    if (sel < 90) return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    if (mirror_count > 0) return mirror_score[$urandom_range(0, mirror_count - 1)];
    return '0;
  endfunction

  task automatic random_beat();
    int               sel;
    func_t            f;
    logic [RANK_W-1:0] r;
    sel = $urandom_range(0, 99);
    if (sel < 50)      f = FUNC_UPDATE;
    else if (sel < 75) f = FUNC_READ;
    else if (sel < 95) f = FUNC_FIND;
    else               f = FUNC_RSVD;
    if (f == FUNC_READ && mirror_count > 0 && $urandom_range(0, 99) < 70)
      r = RANK_W'($urandom_range(0, mirror_count - 1));
    else
      r = RANK_W'($urandom_range(0, 63));
    send_beat(f, pick_key(), pick_score(), r);
  endtask

  task automatic test_empty_table();
    send_beat(FUNC_READ, 32'h0, 32'sh0, 6'd0);
    send_beat(FUNC_READ, 32'hffff_ffff, 32'sh0, 6'd63);
    send_beat(FUNC_FIND, 32'h1234_5678, 32'sh0, 6'd0);
    send_beat(FUNC_RSVD, 32'h0, 32'sh0, 6'd0);
  endtask

  task automatic test_extremes();
    send_beat(FUNC_UPDATE, 32'h0000_0000, 32'sh7fff_ffff, 6'd0);
    send_beat(FUNC_UPDATE, 32'hffff_ffff, 32'sh8000_0000, 6'd63);
    send_beat(FUNC_UPDATE, 32'h0000_0005, 32'sh0, 6'd0);
    // equal scores keep arrival order
    send_beat(FUNC_UPDATE, 32'h0000_0006, 32'sh0, 6'd0);
    send_beat(FUNC_UPDATE, 32'h0000_0007, 32'sh0, 6'd0);
    send_beat(FUNC_READ, 32'h0, 32'sh0, 6'd3);
    send_beat(FUNC_READ, 32'h0, 32'sh0, 6'd63);
    send_beat(FUNC_FIND, 32'hffff_ffff, 32'sh0, 6'd0);
    // known key moves up, stops below an equal score
    send_beat(FUNC_UPDATE, 32'hffff_ffff, 32'sh7fff_ffff, 6'd0);
    // known key moves down to the end
    send_beat(FUNC_UPDATE, 32'h0000_0000, 32'sh8000_0000, 6'd0);
    send_beat(FUNC_UPDATE, 32'h0000_0006, 32'sh0000_0100, 6'd0);
    send_beat(FUNC_UPDATE, 32'h0000_0005, 32'sh0, 6'd0);
    send_beat(FUNC_RSVD, 32'hffff_ffff, 32'shffff_ffff, 6'd63);
    send_beat(FUNC_FIND, 32'h0001_2345, 32'sh0, 6'd0);
    send_beat(FUNC_READ, 32'h0, 32'sh0, 6'd4);
    send_beat(FUNC_READ, 32'h0, 32'sh0, 6'd5);
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) random_beat();
  endtask

  task automatic test_calm_stretch();
    calm = 1'b1;
    repeat (200) random_beat();
    calm = 1'b0;
  endtask

  // receiver holds off long enough for the block to back up into its input
  task automatic test_backpressure();
    hold_seq <= hold_seq + 1;
    calm      = 1'b1;
    repeat (40) random_beat();
    calm      = 1'b0;
  endtask

  task automatic test_pause_drain();
    repeat (60) random_beat();
    drain_results();
    repeat (60) random_beat();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_ack) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_ack  <= hold_seq;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 26);
    end
  end

  always @(posedge clk) begin : check_results
    score_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          err_cnt++;
        end
        if (out_rank_out !== want.rank) begin
          $error("rank_out: expected %0d, actual %0d", want.rank, out_rank_out);
          err_cnt++;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count: expected %0d, actual %0d", want.count, out_entry_count);
          err_cnt++;
        end
        if (out_entry_key !== want.key) begin
          $error("entry_key: expected %h, actual %h", want.key, out_entry_key);
          err_cnt++;
        end
        if (out_entry_score !== want.score) begin
          $error("entry_score: expected %h, actual %h", want.score, out_entry_score);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= FUNC_UPDATE;
    in_player_key <= '0;
    in_new_score  <= '0;
    in_rank_index <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_extremes();
    test_random_mix(400);
    test_calm_stretch();
    test_backpressure();
    test_pause_drain();
    test_random_mix(380);

    drain_results();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ssc_pkg.sv
rtl/ssc_cell.sv
rtl/sorted_score_table.sv
rtl/ssc_checker.sv
tb/sorted_score_table_tb.sv
